// ----- rtl/text_mode_colour_char_renderer_assert.svh -----
// Assertion macros used by the checker of the text renderer.
`ifndef TEXT_MODE_COLOUR_CHAR_RENDERER_ASSERT_SVH
`define TEXT_MODE_COLOUR_CHAR_RENDERER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define TMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/tmc_pkg.sv -----
`timescale 1ns / 1ps

package tmc_pkg;

    localparam int COL_W      = 6;
    localparam int LINE_W     = 8;
    localparam int GROW_W     = 3;
    localparam int GLYPH_ROWS = 8;
    localparam int FRAME_W    = 8;
    localparam int FLASH_BIT  = 4;
    localparam int BYTE_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int PIX_W      = 32;
    localparam int TEXT_AW    = 10;
    localparam int TEXT_DEPTH = 1024;
    localparam int GLYPH_AW   = 11;
    localparam int GLYPH_DEPTH = 2048;

    typedef enum logic [1:0] {
        REQ_CHAR   = 2'd0,
        REQ_COLOUR = 2'd1,
        REQ_GLYPH  = 2'd2,
        REQ_TICK   = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [LINE_W-1:0]  line;
        logic [TEXT_AW-1:0] text_addr;
        logic [GROW_W-1:0]  glyph_row;
        logic               last;
        logic               flash_phase;
    } scan_pos_t;

endpackage

// ----- rtl/tmc_ram.sv -----
`timescale 1ns / 1ps

module tmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tmc_scan.sv -----
`timescale 1ns / 1ps

module tmc_scan
    import tmc_pkg::*;
#(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    output scan_pos_t pos
);

    localparam int CELL_W = LINE_W - GROW_W + COL_W + 1;
    localparam logic [COL_W:0]    COLS_K    = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ROWS * GLYPH_ROWS - 1);

    logic [COL_W-1:0]   column_reg, column_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [CELL_W-1:0]  cell_sum;
    logic               frame_start;

    assign frame_start = (column_reg == '0) && (line_reg == '0);
    assign frame_next  = frame_start ? frame_reg + FRAME_W'(1) : frame_reg;

    // Cell index of the text row that holds this scan line plus the column, wrapped to the store.
    assign cell_sum = CELL_W'(line_reg[LINE_W-1:GROW_W]) * CELL_W'(COLS_K)
                    + CELL_W'(column_reg);

    always_comb begin
        pos.column      = column_reg;
        pos.line        = line_reg;
        pos.text_addr   = cell_sum[TEXT_AW-1:0];
        pos.glyph_row   = line_reg[GROW_W-1:0];
        pos.last        = (column_reg == LAST_COL) && (line_reg == LAST_LINE);
        pos.flash_phase = frame_next[FLASH_BIT];
    end

    always_comb begin
        column_next = column_reg + COL_W'(1);
        line_next   = line_reg;
        if (column_reg == LAST_COL) begin
            column_next = '0;
            line_next   = (line_reg == LAST_LINE) ? '0 : line_reg + LINE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            line_reg   <= '0;
            frame_reg  <= '0;
        end else if (advance) begin
            column_reg <= column_next;
            line_reg   <= line_next;
            frame_reg  <= frame_next;
        end
    end

endmodule

// ----- rtl/text_mode_colour_char_renderer.sv -----
`timescale 1ns / 1ps
// Order: a render tick passes the char/colour read, then the glyph read, then the pixel
// register, which raises m_tvalid.
// Throughput: one request per cycle; a stage of the char/colour read, glyph read and
// pixel register pipeline stalls only while the stage after it is full and held.
// Reset: synchronous, active low; then a pass over all 1024 entries clears the character and colour
// memories with s_tready low. The glyph store keeps its contents and is not cleared.

module text_mode_colour_char_renderer
    import tmc_pkg::*;
#(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mem_address[10:0], write_data[18:11], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixels[31:0], char_column[37:32], scan_line[45:38], zero fill
    output logic        m_tlast    // frame_end
);

    function automatic logic [PIX_W-1:0] expand_pixels(input logic [BYTE_W-1:0]   glyph,
                                                       input logic [NIBBLE_W-1:0] fg,
                                                       input logic [NIBBLE_W-1:0] bg);
        logic [PIX_W-1:0] pix;
        pix = '0;
        for (int b = 0; b < 8; b++) begin
            pix[PIX_W-1-NIBBLE_W*b -: NIBBLE_W] = glyph[7-b] ? fg : bg;
        end
        return pix;
    endfunction

    req_kind_t            req;
    logic [GLYPH_AW-1:0]  req_addr;
    logic [BYTE_W-1:0]    req_data;
    logic                 accept;
    logic                 tick_acc;

    logic                 clear_reg;
    logic [TEXT_AW-1:0]   clr_addr_reg;

    logic                 adv0, adv1, adv2;
    scan_pos_t            pos;

    logic                 char_we, colour_we, glyph_we, glyph_re;
    logic [TEXT_AW-1:0]   text_waddr;
    logic [BYTE_W-1:0]    text_wdata;
    logic [BYTE_W-1:0]    char_rdata, colour_rdata, glyph_rdata;

    logic                 v1_reg;
    scan_pos_t            pos1_reg;

    logic                 v2_reg;
    logic [NIBBLE_W-1:0]  fg2_reg, bg2_reg;
    logic [COL_W-1:0]     column2_reg;
    logic [LINE_W-1:0]    line2_reg;
    logic                 last2_reg;
    logic [NIBBLE_W-1:0]  fg_sel, bg_sel;
    logic                 swap;

    logic                 m_valid_reg;
    logic [PIX_W-1:0]     pixels_reg;
    logic [COL_W-1:0]     column_o_reg;
    logic [LINE_W-1:0]    line_o_reg;
    logic                 last_o_reg;

    assign req      = req_kind_t'(s_tuser);
    assign req_addr = s_tdata[GLYPH_AW-1:0];
    assign req_data = s_tdata[GLYPH_AW +: BYTE_W];

    // Each stage moves on when the stage after it is empty or is moving too.
    assign adv2 = !m_valid_reg || m_tready;
    assign adv1 = !v2_reg || adv2;
    assign adv0 = !v1_reg || adv1;

    assign s_tready = adv0 && !clear_reg;
    assign accept   = s_tvalid && s_tready;
    assign tick_acc = accept && (req == REQ_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clear_reg) begin
            clr_addr_reg <= clr_addr_reg + TEXT_AW'(1);
            if (clr_addr_reg == TEXT_AW'(TEXT_DEPTH - 1)) begin
                clear_reg <= 1'b0;
            end
        end
    end

    tmc_scan #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_scan (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(tick_acc),
        .pos    (pos)
    );

    assign text_waddr = clear_reg ? clr_addr_reg : req_addr[TEXT_AW-1:0];
    assign text_wdata = clear_reg ? '0 : req_data;
    assign char_we    = clear_reg || (accept && (req == REQ_CHAR));
    assign colour_we  = clear_reg || (accept && (req == REQ_COLOUR));
    assign glyph_we   = accept && (req == REQ_GLYPH);
    assign glyph_re   = adv1 && v1_reg;

    tmc_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_char_ram (
        .aclk (aclk),
        .we   (char_we),
        .waddr(text_waddr),
        .wdata(text_wdata),
        .re   (tick_acc),
        .raddr(pos.text_addr),
        .rdata(char_rdata)
    );

    tmc_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_colour_ram (
        .aclk (aclk),
        .we   (colour_we),
        .waddr(text_waddr),
        .wdata(text_wdata),
        .re   (tick_acc),
        .raddr(pos.text_addr),
        .rdata(colour_rdata)
    );

    tmc_ram #(.WIDTH(BYTE_W), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
        .aclk (aclk),
        .we   (glyph_we),
        .waddr(req_addr),
        .wdata(req_data),
        .re   (glyph_re),
        .raddr({char_rdata, pos1_reg.glyph_row}),
        .rdata(glyph_rdata)
    );

    // Flashing cells swap foreground and background.
    assign swap   = colour_rdata[BYTE_W-1] && pos1_reg.flash_phase;
    assign fg_sel = swap ? colour_rdata[NIBBLE_W-1:0] : colour_rdata[BYTE_W-1:NIBBLE_W];
    assign bg_sel = swap ? colour_rdata[BYTE_W-1:NIBBLE_W] : colour_rdata[NIBBLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv0) begin
                v1_reg <= tick_acc;
            end
            if (adv1) begin
                v2_reg <= v1_reg;
            end
            if (adv2) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            pos1_reg <= pos;
        end
        if (glyph_re) begin
            fg2_reg     <= fg_sel;
            bg2_reg     <= bg_sel;
            column2_reg <= pos1_reg.column;
            line2_reg   <= pos1_reg.line;
            last2_reg   <= pos1_reg.last;
        end
        if (adv2 && v2_reg) begin
            pixels_reg   <= expand_pixels(glyph_rdata, fg2_reg, bg2_reg);
            column_o_reg <= column2_reg;
            line_o_reg   <= line2_reg;
            last_o_reg   <= last2_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, line_o_reg, column_o_reg, pixels_reg};
    assign m_tlast  = last_o_reg;

endmodule

// ----- rtl/tmc_checker.sv -----
`timescale 1ns / 1ps
`include "text_mode_colour_char_renderer_assert.svh"

module tmc_checker #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 24
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    localparam logic [5:0] LAST_COL  = 6'(COLUMNS - 1);
    localparam logic [7:0] LAST_LINE = 8'(ROWS * 8 - 1);

    logic [5:0] out_col;
    logic [7:0] out_line;
    logic       at_last;

    assign out_col  = m_tdata[37:32];
    assign out_line = m_tdata[45:38];
    assign at_last  = (out_col == LAST_COL) && (out_line == LAST_LINE);

    // No result and no request taken straight after reset: the clearing pass runs first.
    `TMC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid && !s_tready, "busy after reset")
    // A stalled result holds.
    `TMC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed")
    // Frame end exactly on the last cell of the last scan line.
    `TMC_ASSERT(a_frame_end, m_tvalid |-> m_tlast == at_last, "bad frame end")
    // Column and scan line stay inside the screen.
    `TMC_ASSERT(a_col_range, m_tvalid |-> out_col <= LAST_COL && out_line <= LAST_LINE, "bad position")

endmodule

bind text_mode_colour_char_renderer tmc_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tmc_pkg::*;

    localparam int COLUMNS     = 40;
    localparam int ROWS        = 24;
    localparam int TOTAL_LINES = ROWS * GLYPH_ROWS;

    typedef struct packed {
        logic [31:0] pixels;
        logic [5:0]  char_column;
        logic [7:0]  scan_line;
        logic        frame_end;
    } render_out_t;

    class render_scoreboard;
        logic [7:0]  char_mem   [TEXT_DEPTH];
        logic [7:0]  colour_mem [TEXT_DEPTH];
        logic [7:0]  glyph_mem  [GLYPH_DEPTH];
        logic [5:0]  col_pos;
        logic [7:0]  line_pos;
        logic [7:0]  frame_cnt;
        render_out_t pending_q[$];
        int          errors;

        function new();
            foreach (char_mem[i]) char_mem[i] = 8'd0;
            foreach (colour_mem[i]) colour_mem[i] = 8'd0;
            foreach (glyph_mem[i]) glyph_mem[i] = 8'd0;
            col_pos   = '0;
            line_pos  = '0;
            frame_cnt = '0;
            errors    = 0;
        endfunction

        // Update the stores, or work out the pixels of the current cell on a tick.
        function void note_request(req_kind_t kind, logic [10:0] addr, logic [7:0] data);
            logic [9:0]  cell_idx;
            logic [7:0]  chr;
            logic [7:0]  clr;
            logic [7:0]  gfx;
            logic [3:0]  fg;
            logic [3:0]  bg;
            logic [3:0]  tmp;
            logic [31:0] pix;
            render_out_t want;
            case (kind)
                REQ_CHAR:   char_mem[addr[9:0]] = data;
                REQ_COLOUR: colour_mem[addr[9:0]] = data;
                REQ_GLYPH:  glyph_mem[addr] = data;
                default: begin
                    if (col_pos == 0 && line_pos == 0)
                        frame_cnt = frame_cnt + 8'd1;
                    cell_idx = 10'((int'(line_pos) / GLYPH_ROWS) * COLUMNS + int'(col_pos));
                    chr = char_mem[cell_idx];
                    clr = colour_mem[cell_idx];
                    gfx = glyph_mem[{chr, line_pos[2:0]}];
                    fg  = clr[7:4];
                    bg  = clr[3:0];
                    // flash: swap the two indices in alternate blocks of 16 frames
                    if (clr[7] && frame_cnt[FLASH_BIT]) begin
                        tmp = fg;
                        fg  = bg;
                        bg  = tmp;
                    end
                    pix = '0;
                    for (int b = 7; b >= 0; b--)
                        pix = {pix[27:0], gfx[b] ? fg : bg};
                    want.pixels      = pix;
                    want.char_column = col_pos;
                    want.scan_line   = line_pos;
                    want.frame_end   = (col_pos == COLUMNS - 1) && (line_pos == TOTAL_LINES - 1);
                    pending_q.push_back(want);
                    if (col_pos == COLUMNS - 1) begin
                        col_pos = '0;
                        line_pos = (line_pos == TOTAL_LINES - 1) ? 8'd0 : line_pos + 8'd1;
                    end else begin
                        col_pos = col_pos + 6'd1;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [31:0] pixels, logic [5:0] char_column,
                                   logic [7:0] scan_line, logic frame_end);
            render_out_t want;
            if (pending_q.size() == 0) begin
                $error("result with no render tick pending");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (pixels !== want.pixels) begin
                $error("pixels: expected %h, got %h", want.pixels, pixels);
                errors++;
            end
            if (char_column !== want.char_column) begin
                $error("char_column: expected %0d, got %0d", want.char_column, char_column);
                errors++;
            end
            if (scan_line !== want.scan_line) begin
                $error("scan_line: expected %0d, got %0d", want.scan_line, scan_line);
                errors++;
            end
            if (frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // mem_address[10:0], write_data[18:11], zero fill
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pixels[31:0], char_column[37:32], scan_line[45:38], zero fill
    logic        m_tlast;   // frame_end

    render_scoreboard sb;
    bit               tx_idle_on;
    bit               rx_idle_on;
    logic [7:0]       rows_done [256];
    logic [7:0]       ready_chars[$];

    text_mode_colour_char_renderer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(req_kind_t'(s_tuser), s_tdata[10:0], s_tdata[18:11]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[31:0], m_tdata[37:32], m_tdata[45:38], m_tlast);
        end
    end

    // Result side: stall in random bursts while idling is enabled.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(req_kind_t kind, logic [10:0] addr, logic [7:0] data);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        // a character only becomes usable once all eight glyph rows hold data
        if (kind == REQ_GLYPH) begin
            if (rows_done[addr[10:3]] != 8'hFF) begin
                rows_done[addr[10:3]][addr[2:0]] = 1'b1;
                if (rows_done[addr[10:3]] == 8'hFF)
                    ready_chars.push_back(addr[10:3]);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random();
        int         roll;
        logic [10:0] addr;
        logic [7:0]  data;
        logic [7:0]  chr;
        roll = $urandom_range(0, 99);
        addr = 11'($urandom_range(0, 2047));
        data = 8'($urandom_range(0, 255));
        if (roll < 50) begin
            send_request(REQ_TICK, addr, data);
        end else if (roll < 65) begin
            send_request(REQ_CHAR, addr, ready_chars[$urandom_range(0, ready_chars.size() - 1)]);
        end else if (roll < 80) begin
            send_request(REQ_COLOUR, addr, data);
        end else if (roll < 90) begin
            // load a whole glyph for one character
            chr = 8'($urandom_range(0, 255));
            for (int r = 0; r < GLYPH_ROWS; r++)
                send_request(REQ_GLYPH, {chr, 3'(r)}, 8'($urandom_range(0, 255)));
        end else begin
            send_request(REQ_GLYPH, addr, data);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        foreach (rows_done[i]) rows_done[i] = 8'h00;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_CHAR;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // glyphs for characters 0 and 255, then edge addresses and a few ticks
        send_request(REQ_GLYPH, 11'h000, 8'h00);
        send_request(REQ_GLYPH, 11'h001, 8'hFF);
        send_request(REQ_GLYPH, 11'h002, 8'hAA);
        send_request(REQ_GLYPH, 11'h003, 8'h55);
        send_request(REQ_GLYPH, 11'h004, 8'h80);
        send_request(REQ_GLYPH, 11'h005, 8'h01);
        send_request(REQ_GLYPH, 11'h006, 8'hF0);
        send_request(REQ_GLYPH, 11'h007, 8'h0F);
        for (int r = 0; r < GLYPH_ROWS; r++)
            send_request(REQ_GLYPH, {8'hFF, 3'(r)}, 8'(8'hFF >> r));
        send_request(REQ_CHAR, 11'h7FF, 8'hFF);
        send_request(REQ_CHAR, 11'h000, 8'hFF);
        send_request(REQ_COLOUR, 11'h000, 8'hF0);
        send_request(REQ_COLOUR, 11'h401, 8'h8F);
        send_request(REQ_COLOUR, 11'h7FF, 8'hFF);
        repeat (4) send_request(REQ_TICK, 11'h7FF, 8'hFF);

        repeat (300) send_random();
        wait_idle();

        repeat (300) send_random();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (150) send_random();
        wait_idle();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
